### rtl/rssu_pkg.sv
// Shared types and constants for the resonant state-space update block.
`default_nettype none

package rssu_pkg;

  localparam int NUM_STATES    = 8;
  localparam int NUM_INPUTS    = 2;
  localparam int TABLE_DEPTH   = NUM_STATES * NUM_STATES + NUM_STATES * NUM_INPUTS;
  localparam int B_BASE        = NUM_STATES * NUM_STATES;
  localparam int STATE_W       = 32;
  localparam int COEF_IN_W     = 24;
  localparam int COEF_WIDTH    = 24;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  localparam int IDX_W         = $clog2(NUM_STATES);
  localparam int TERMS_PER_ROW = NUM_STATES + NUM_INPUTS;
  localparam int TERM_W        = $clog2(TERMS_PER_ROW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } fsm_t;

  typedef enum logic [1:0] {
    SRC_STATE,
    SRC_ALPHA,
    SRC_BETA
  } src_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } term_tag_t;

endpackage

`default_nettype wire

### rtl/resonant_state_space_update.sv
// Top level: sequencer, coefficient and state memories, shared MAC, output register.
//
//   channel | direction | beat
//   in_     | input     | func, coef_index, coef_value, err_alpha, err_beta
//   out_    | output    | new_state_0 .. new_state_7
//
// A coefficient load gives no beat.
// A sample step issues 80 products through one shared multiply-accumulate, one per cycle;
// out_valid rises when the output register loads; the next beat is taken in idle.
// in_stall is high while a step is in flight or its beat waits for the output register.
// Synchronous active-low reset clears the state vector (via valid bits) and all control.
// out_stall holds the output register; a later step waits before overwriting it.
`default_nettype none

module resonant_state_space_update #(
  parameter int CoefWidth = rssu_pkg::COEF_WIDTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_func,
  input  wire logic       [6:0]                   in_coef_index,
  input  wire logic signed [rssu_pkg::COEF_IN_W-1:0] in_coef_value,
  input  wire logic signed [31:0]                 in_err_alpha,
  input  wire logic signed [31:0]                 in_err_beta,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [31:0]                      out_new_state_0,
  output logic signed [31:0]                      out_new_state_1,
  output logic signed [31:0]                      out_new_state_2,
  output logic signed [31:0]                      out_new_state_3,
  output logic signed [31:0]                      out_new_state_4,
  output logic signed [31:0]                      out_new_state_5,
  output logic signed [31:0]                      out_new_state_6,
  output logic signed [31:0]                      out_new_state_7
);
  import rssu_pkg::*;

  localparam logic [IDX_W-1:0]  LastRow  = IDX_W'(NUM_STATES - 1);
  localparam logic [TERM_W-1:0] LastTerm = TERM_W'(TERMS_PER_ROW - 1);
  localparam logic [TERM_W-1:0] AlphaTerm = TERM_W'(NUM_STATES);

  fsm_t                 fsm_r, fsm_nxt;
  logic                 in_acc;
  logic                 step_acc;
  logic                 load_en;
  logic                 issue;
  logic                 done;
  logic                 out_load;
  logic                 bank_r;
  logic [IDX_W-1:0]     row_r;
  logic [TERM_W-1:0]    term_r;
  logic [IDX_W-1:0]     wr_row_r;
  logic [STATE_W-1:0]   err_alpha_r;
  logic [STATE_W-1:0]   err_beta_r;
  term_tag_t            iss_tag;
  term_tag_t            rd_tag_r;
  src_t                 iss_src;
  src_t                 rd_src_r;
  logic [ADDR_W-1:0]    coef_rd_addr;
  logic [CoefWidth-1:0] coef_wr_data;
  logic [CoefWidth-1:0] coef_rd_data;
  logic [STATE_W-1:0]   state_rd_data;
  logic [STATE_W-1:0]   mac_value;
  logic                 res_valid;
  logic [STATE_W-1:0]   res;
  logic [STATE_W-1:0]   next_vec_r [NUM_STATES];
  logic [STATE_W-1:0]   out_state_r [NUM_STATES];
  logic                 out_valid_r;

  assign in_acc   = in_valid && !in_stall;
  assign step_acc = in_acc && in_func;
  assign load_en  = in_acc && !in_func && (in_coef_index < ADDR_W'(TABLE_DEPTH));
  assign done     = res_valid && (wr_row_r == LastRow);

  if (CoefWidth <= COEF_IN_W) begin : g_coef_narrow
    assign coef_wr_data = in_coef_value[CoefWidth-1:0];
  end else begin : g_coef_wide
    assign coef_wr_data = {{(CoefWidth - COEF_IN_W){1'b0}}, in_coef_value};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r <= ST_IDLE;
    end else begin
      fsm_r <= fsm_nxt;
    end
  end

  always_comb begin
    fsm_nxt  = fsm_r;
    in_stall = 1'b1;
    issue    = 1'b0;
    out_load = 1'b0;
    unique case (fsm_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && in_func) begin
          fsm_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if (row_r == LastRow && term_r == LastTerm) begin
          fsm_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (done) begin
          fsm_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load = 1'b1;
          fsm_nxt  = ST_IDLE;
        end
      end
      default: fsm_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    iss_tag.valid = issue;
    iss_tag.first = (term_r == '0);
    iss_tag.last  = (term_r == LastTerm);
    if (term_r < AlphaTerm) begin
      iss_src = SRC_STATE;
    end else if (term_r == AlphaTerm) begin
      iss_src = SRC_ALPHA;
    end else begin
      iss_src = SRC_BETA;
    end
    if (term_r < AlphaTerm) begin
      coef_rd_addr = ADDR_W'({row_r, term_r[IDX_W-1:0]});
    end else begin
      coef_rd_addr = ADDR_W'(B_BASE) + ADDR_W'({row_r, term_r[0]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      term_r   <= '0;
      wr_row_r <= '0;
      bank_r   <= 1'b0;
      rd_tag_r <= '0;
    end else begin
      rd_tag_r <= iss_tag;
      if (step_acc) begin
        row_r    <= '0;
        term_r   <= '0;
        wr_row_r <= '0;
      end else if (issue) begin
        if (term_r == LastTerm) begin
          term_r <= '0;
          row_r  <= row_r + 1'b1;
        end else begin
          term_r <= term_r + 1'b1;
        end
      end
      if (res_valid) begin
        wr_row_r <= wr_row_r + 1'b1;
      end
      if (done) begin
        bank_r <= ~bank_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_acc) begin
      err_alpha_r <= in_err_alpha;
      err_beta_r  <= in_err_beta;
    end
    rd_src_r <= iss_src;
    if (res_valid) begin
      next_vec_r[wr_row_r] <= res;
    end
    if (out_load) begin
      out_state_r <= next_vec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    case (rd_src_r)
      SRC_ALPHA: mac_value = err_alpha_r;
      SRC_BETA:  mac_value = err_beta_r;
      default:   mac_value = state_rd_data;
    endcase
  end

  rssu_coef_mem #(
    .CoefWidth(CoefWidth)
  ) u_coef_mem (
    .clk    (clk),
    .wr_en  (load_en),
    .wr_addr(in_coef_index[ADDR_W-1:0]),
    .wr_data(coef_wr_data),
    .rd_en  (issue),
    .rd_addr(coef_rd_addr),
    .rd_data(coef_rd_data)
  );

  rssu_state_mem u_state_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (issue),
    .rd_bank(bank_r),
    .rd_idx (term_r[IDX_W-1:0]),
    .rd_data(state_rd_data),
    .wr_en  (res_valid),
    .wr_bank(~bank_r),
    .wr_idx (wr_row_r),
    .wr_data(res)
  );

  rssu_mac #(
    .CoefWidth(CoefWidth)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .term_i     (rd_tag_r),
    .coef_i     (coef_rd_data),
    .value_i    (mac_value),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  assign out_valid       = out_valid_r;
  assign out_new_state_0 = out_state_r[0];
  assign out_new_state_1 = out_state_r[1];
  assign out_new_state_2 = out_state_r[2];
  assign out_new_state_3 = out_state_r[3];
  assign out_new_state_4 = out_state_r[4];
  assign out_new_state_5 = out_state_r[5];
  assign out_new_state_6 = out_state_r[6];
  assign out_new_state_7 = out_state_r[7];

endmodule

`default_nettype wire

### rtl/rssu_coef_mem.sv
// Coefficient table: one write port, one registered read port.
`default_nettype none

module rssu_coef_mem #(
  parameter int CoefWidth = rssu_pkg::COEF_WIDTH
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [rssu_pkg::ADDR_W-1:0] wr_addr,
  input  wire logic [CoefWidth-1:0]        wr_data,
  input  wire logic                        rd_en,
  input  wire logic [rssu_pkg::ADDR_W-1:0] rd_addr,
  output logic      [CoefWidth-1:0]        rd_data
);
  import rssu_pkg::*;

  logic [CoefWidth-1:0] mem [TABLE_DEPTH];
  logic [CoefWidth-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/rssu_state_mem.sv
// Ping-pong state memory with per-entry valid bits; unwritten entries read as zero.
`default_nettype none

module rssu_state_mem (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          rd_en,
  input  wire logic                          rd_bank,
  input  wire logic [rssu_pkg::IDX_W-1:0]    rd_idx,
  output logic      [rssu_pkg::STATE_W-1:0]  rd_data,
  input  wire logic                          wr_en,
  input  wire logic                          wr_bank,
  input  wire logic [rssu_pkg::IDX_W-1:0]    wr_idx,
  input  wire logic [rssu_pkg::STATE_W-1:0]  wr_data
);
  import rssu_pkg::*;

  localparam int Depth = 2 * NUM_STATES;
  localparam int AW    = IDX_W + 1;

  logic [STATE_W-1:0] mem [Depth];
  logic [Depth-1:0]   valid_r;
  logic [STATE_W-1:0] rd_data_r;
  logic               rd_ok_r;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;

  assign rd_addr = {rd_bank, rd_idx};
  assign wr_addr = {wr_bank, wr_idx};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_ok_r ? rd_data_r : '0;

endmodule

`default_nettype wire

### rtl/rssu_mac.sv
// Pipelined multiply, round and saturating row accumulate.
`default_nettype none

module rssu_mac #(
  parameter int CoefWidth = rssu_pkg::COEF_WIDTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire rssu_pkg::term_tag_t                 term_i,
  input  wire logic signed [CoefWidth-1:0]         coef_i,
  input  wire logic signed [rssu_pkg::STATE_W-1:0] value_i,
  output logic                                     res_valid_o,
  output logic             [rssu_pkg::STATE_W-1:0] res_o
);
  import rssu_pkg::*;

  localparam int Frac   = CoefWidth - 2;
  localparam int ProdW  = CoefWidth + STATE_W;
  localparam int RndW   = ProdW - Frac;
  localparam int AccW   = RndW + 4;
  localparam logic [ProdW-1:0] RoundK = ProdW'(1) << (Frac - 1);

  logic signed [ProdW-1:0] prod_r;
  term_tag_t               tag1_r;
  logic signed [RndW-1:0]  rnd_r;
  term_tag_t               tag2_r;
  logic signed [AccW-1:0]  acc_r;
  logic signed [AccW-1:0]  acc_nxt;
  logic signed [ProdW-1:0] rsum;
  logic                    ovf;
  logic [STATE_W-1:0]      sat;
  logic                    res_valid_r;
  logic [STATE_W-1:0]      res_r;

  assign rsum    = prod_r + $signed(RoundK);
  assign acc_nxt = tag2_r.first ? AccW'(rnd_r) : acc_r + AccW'(rnd_r);
  assign ovf     = (acc_nxt[AccW-1:STATE_W-1] != '0) && (acc_nxt[AccW-1:STATE_W-1] != '1);
  assign sat     = ovf ? (acc_nxt[AccW-1] ? {1'b1, {(STATE_W-1){1'b0}}}
                                          : {1'b0, {(STATE_W-1){1'b1}}})
                       : acc_nxt[STATE_W-1:0];

  always_ff @(posedge clk) begin
    prod_r <= ProdW'(coef_i) * ProdW'(value_i);
    rnd_r  <= rsum[ProdW-1:Frac];
    if (tag2_r.valid) begin
      acc_r <= acc_nxt;
    end
    if (tag2_r.valid && tag2_r.last) begin
      res_r <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r      <= '0;
      tag2_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      tag1_r      <= term_i;
      tag2_r      <= tag1_r;
      res_valid_r <= tag2_r.valid && tag2_r.last;
    end
  end

  assign res_valid_o = res_valid_r;
  assign res_o       = res_r;

endmodule

`default_nettype wire

### rtl/rssu_checker.sv
// Port-level checks for the resonant state-space update block, bound to the top level.
`default_nettype none

module rssu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_func,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_new_state_0
);

  // step beat enters the row-by-row computation: input must stall next cycle
  a_step_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func |=> in_stall)
    else $error("step accepted without stalling input");

  // coefficient load never produces an output beat
  a_load_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_func && !out_valid |=> !out_valid)
    else $error("coefficient load produced an output beat");

  // idle input side with no pending output cannot raise out_valid
  a_idle_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall && !in_valid && !out_valid |=> !out_valid)
    else $error("output beat without a step in flight");

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_new_state_0))
    else $error("stalled output beat changed");

  // reset leaves the block idle with no output beat
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind resonant_state_space_update rssu_checker u_rssu_checker (.*);

`default_nettype wire
